/* design/vrlu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrlu_pkg
// shared constants and types of the variable ratio linear upsampler
// ----------------------------------------------------------------------------
package vrlu_pkg;

  localparam int XW              = 32;  // q16.16 sample width
  localparam int CNT_W           = 6;   // insert count field width
  localparam int START_W         = 16;  // start index register width
  localparam int GRID_W          = 16;  // grid index field width
  localparam int MAX_INSERT_DEF  = 63;
  localparam int INDEX_BITS_DEF  = 16;

  localparam int IN_TDATA_W      = 72;  // 70 bits of fields, padded to bytes
  localparam int OUT_TDATA_W     = 80;

  // status of the iterative divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : vrlu_pkg
`default_nettype wire

/* design/vrlu_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrlu_div
// bit-serial restoring divider, unsigned, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vrlu_div #(
  parameter int NW = 33,
  parameter int DW = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NW-1:0]      dividend,
  input  wire logic [DW-1:0]      divisor,
  output vrlu_pkg::div_stat_t     stat,
  output logic      [NW-1:0]      quotient,
  output logic      [DW-1:0]      remainder
);
  import vrlu_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r,  quo_nxt;
  logic [DW-1:0] rem_r,  rem_nxt;
  logic [DW-1:0] dvs_r,  dvs_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[NW-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    ge       = !diff[DW];
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule : vrlu_div
`default_nettype wire

/* design/variable_ratio_linear_upsampler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_ratio_linear_upsampler
// places sample points on a dense grid and inserts linearly weighted points
// between each held sample and the next one
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------------
//  in_     | in  | tdata: sample_x, sample_y, insert_count; tuser: begins_set
//  out_    | out | tdata: grid_index, point_x, point_y; tuser: is_original;
//          |     | tlast: last_of_run
//  cfg_    | in  | data: start_index
//
//  an input beat that starts a set, or whose held sample has no inserts,
//  goes straight to its original point; for h inserted points it runs
//  one pass of the serial divider on (x - held_x), then gives one point per
//  cycle while the output is free, from a running quotient/remainder accumulator
//  in_tready is high only while the sequencer is idle; the output register
//  holds a point while out_tready is low and the sequencer waits on it
//  synchronous active-low reset; no sample is held after reset
// ----------------------------------------------------------------------------
module variable_ratio_linear_upsampler #(
  parameter int MAX_INSERT = vrlu_pkg::MAX_INSERT_DEF,
  parameter int INDEX_BITS = vrlu_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // sample_x [31:0], sample_y [63:32], insert_count [69:64], zero pad
  input  wire logic [vrlu_pkg::IN_TDATA_W-1:0]     in_tdata,
  // begins_set [0]
  input  wire logic                                in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // grid_index [15:0], point_x [47:16], point_y [79:48]
  output logic      [vrlu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // is_original [0]
  output logic                                     out_tuser,
  output logic                                     out_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // start_index
  input  wire logic [vrlu_pkg::START_W-1:0]        cfg_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready
);
  import vrlu_pkg::*;

  localparam int IW  = INDEX_BITS;
  localparam int CW  = $clog2(MAX_INSERT + 1);  // held insert count
  localparam int DW  = CW + 1;                  // denominator h+1
  localparam int NW  = XW + 1;                  // |x1 - x0|
  localparam int QW  = XW + 2;                  // running quotient

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_INTERP,
    S_ORIG
  } state_t;

  // input fields
  logic [XW-1:0]    in_x, in_y;
  logic [CNT_W-1:0] in_cnt;
  logic [CW-1:0]    cnt_sat;
  logic             in_beat;

  assign in_x    = in_tdata[XW-1:0];
  assign in_y    = in_tdata[2*XW-1:XW];
  assign in_cnt  = in_tdata[2*XW+CNT_W-1:2*XW];
  assign cnt_sat = (in_cnt > CNT_W'(MAX_INSERT)) ? CW'(MAX_INSERT) : CW'(in_cnt);
  assign in_beat = in_tvalid && in_tready;

  // registers
  state_t           state_r,     state_nxt;
  logic [START_W-1:0] start_r,   start_nxt;
  logic             have_held_r, have_held_nxt;
  logic [XW-1:0]    held_x_r,    held_x_nxt;
  logic [CW-1:0]    held_cnt_r,  held_cnt_nxt;
  logic [IW-1:0]    held_idx_r,  held_idx_nxt;
  logic [XW-1:0]    new_x_r,     new_x_nxt;
  logic [XW-1:0]    new_y_r,     new_y_nxt;
  logic [CW-1:0]    new_cnt_r,   new_cnt_nxt;
  logic [IW-1:0]    orig_idx_r,  orig_idx_nxt;
  logic [IW-1:0]    pt_idx_r,    pt_idx_nxt;
  logic [CW-1:0]    left_r,      left_nxt;
  logic             d_neg_r,     d_neg_nxt;
  logic [QW-1:0]    q_r,         q_nxt;
  logic [DW-1:0]    r_r,         r_nxt;
  logic [QW-1:0]    dq_r,        dq_nxt;
  logic [DW-1:0]    dr_r,        dr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [GRID_W-1:0] o_idx_r,    o_idx_nxt;
  logic [XW-1:0]    o_x_r,       o_x_nxt;
  logic [XW-1:0]    o_y_r,       o_y_nxt;
  logic             o_orig_r,    o_orig_nxt;

  // divider hookup
  div_stat_t        div_stat;
  logic             div_start;
  logic [NW-1:0]    div_num;
  logic [DW-1:0]    div_den;
  logic [NW-1:0]    div_quo;
  logic [DW-1:0]    div_rem;

  // datapath helpers
  logic [NW-1:0]    d_diff;
  logic [DW-1:0]    den;
  logic [DW:0]      r_sum;
  logic             r_wrap;
  logic [DW-1:0]    r_step;
  logic [QW-1:0]    q_step;
  logic [XW-1:0]    x_trunc;
  logic             out_free;

  assign den      = {1'b0, held_cnt_r} + DW'(1);
  assign d_diff   = {in_x[XW-1], in_x} - {held_x_r[XW-1], held_x_r};
  assign div_num  = d_diff[NW-1] ? (~d_diff + NW'(1)) : d_diff;
  assign div_den  = den;
  assign out_free = !out_valid_r || out_tready;

  // one accumulator step: num_j = num_(j-1) + d kept as floor quotient/remainder
  assign r_sum   = {1'b0, r_r} + {1'b0, dr_r};
  assign r_wrap  = (r_sum >= {1'b0, den});
  assign r_step  = r_wrap ? DW'(r_sum - {1'b0, den}) : r_sum[DW-1:0];
  assign q_step  = q_r + dq_r + QW'(r_wrap);
  // floor to truncation toward zero
  assign x_trunc = q_step[XW-1:0] + XW'(q_step[QW-1] && (r_step != '0));

  vrlu_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    have_held_nxt = have_held_r;
    held_x_nxt    = held_x_r;
    held_cnt_nxt  = held_cnt_r;
    held_idx_nxt  = held_idx_r;
    new_x_nxt     = new_x_r;
    new_y_nxt     = new_y_r;
    new_cnt_nxt   = new_cnt_r;
    orig_idx_nxt  = orig_idx_r;
    pt_idx_nxt    = pt_idx_r;
    left_nxt      = left_r;
    d_neg_nxt     = d_neg_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    dq_nxt        = dq_r;
    dr_nxt        = dr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_idx_nxt     = o_idx_r;
    o_x_nxt       = o_x_r;
    o_y_nxt       = o_y_r;
    o_orig_nxt    = o_orig_r;
    div_start     = 1'b0;

    // the user must send config beats only while idle; the block itself does not enforce it
    if (cfg_valid) begin
      start_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          new_x_nxt   = in_x;
          new_y_nxt   = in_y;
          new_cnt_nxt = cnt_sat;
          if (in_tuser || !have_held_r) begin
            // new set: the sample alone, at the start index
            orig_idx_nxt = IW'(start_r);
            state_nxt    = S_ORIG;
          end else begin
            orig_idx_nxt = held_idx_r + IW'(held_cnt_r) + IW'(1);
            if (held_cnt_r == '0) begin
              state_nxt = S_ORIG;
            end else begin
              // num_0 = held_x * (h+1): quotient held_x, remainder zero
              div_start  = 1'b1;
              d_neg_nxt  = d_diff[NW-1];
              q_nxt      = {{(QW-XW){held_x_r[XW-1]}}, held_x_r};
              r_nxt      = '0;
              pt_idx_nxt = held_idx_r;
              left_nxt   = held_cnt_r;
              state_nxt  = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        if (div_stat.done) begin
          // floor division of the signed step by h+1
          if (d_neg_r && (div_rem != '0)) begin
            dq_nxt = ~{{(QW-NW){1'b0}}, div_quo};
            dr_nxt = den - div_rem;
          end else if (d_neg_r) begin
            dq_nxt = ~{{(QW-NW){1'b0}}, div_quo} + QW'(1);
            dr_nxt = div_rem;
          end else begin
            dq_nxt = {{(QW-NW){1'b0}}, div_quo};
            dr_nxt = div_rem;
          end
          state_nxt = S_INTERP;
        end
      end

      S_INTERP: begin
        if (out_free) begin
          q_nxt         = q_step;
          r_nxt         = r_step;
          pt_idx_nxt    = pt_idx_r + IW'(1);
          left_nxt      = left_r - CW'(1);
          out_valid_nxt = 1'b1;
          o_idx_nxt     = GRID_W'(pt_idx_r + IW'(1));
          o_x_nxt       = x_trunc;
          o_y_nxt       = '0;
          o_orig_nxt    = 1'b0;
          if (left_r == CW'(1)) begin
            state_nxt = S_ORIG;
          end
        end
      end

      S_ORIG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_idx_nxt     = GRID_W'(orig_idx_r);
          o_x_nxt       = new_x_r;
          o_y_nxt       = new_y_r;
          o_orig_nxt    = 1'b1;
          held_x_nxt    = new_x_r;
          held_cnt_nxt  = new_cnt_r;
          held_idx_nxt  = orig_idx_r;
          have_held_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= '0;
      have_held_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      have_held_r <= have_held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    held_x_r   <= held_x_nxt;
    held_cnt_r <= held_cnt_nxt;
    held_idx_r <= held_idx_nxt;
    new_x_r    <= new_x_nxt;
    new_y_r    <= new_y_nxt;
    new_cnt_r  <= new_cnt_nxt;
    orig_idx_r <= orig_idx_nxt;
    pt_idx_r   <= pt_idx_nxt;
    left_r     <= left_nxt;
    d_neg_r    <= d_neg_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    dq_r       <= dq_nxt;
    dr_r       <= dr_nxt;
    o_idx_r    <= o_idx_nxt;
    o_x_r      <= o_x_nxt;
    o_y_r      <= o_y_nxt;
    o_orig_r   <= o_orig_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_y_r, o_x_r, o_idx_r};
  assign out_tuser  = o_orig_r;
  // an original point always closes the run of its input beat
  assign out_tlast  = o_orig_r;

endmodule : variable_ratio_linear_upsampler
`default_nettype wire

/* design/vrlu_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrlu_chk
// port-level checks of the upsampler, bound to the top level
// ----------------------------------------------------------------------------
module vrlu_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic [vrlu_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                               out_tuser,
  input wire logic                               out_tlast,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready
);
  import vrlu_pkg::*;

  // a stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // an accepted input beat leaves in_tready low in the cycle after it
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a beat");

  // while an inserted point sits on the output the original point is still owed
  a_orig_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !in_tready)
    else $error("block idle before the original point was sent");

endmodule : vrlu_chk

bind variable_ratio_linear_upsampler vrlu_chk u_vrlu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire
